[rtl/vertex_edge_scatter_max_table_macros.svh]
// Assertion macros shared by the checker.
`ifndef VERTEX_EDGE_SCATTER_MAX_TABLE_MACROS_SVH
`define VERTEX_EDGE_SCATTER_MAX_TABLE_MACROS_SVH

// Checked at every edge outside reset.
`define VEST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define VEST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/vest_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package vest_pkg;

  localparam int MaxVerticesDef     = 1024;
  localparam int MaxPatternEdgesDef = 16;

  localparam int CmdW    = 2;
  localparam int VertexW = 10;
  localparam int EdgeW   = 4;
  localparam int ValueW  = 32;
  localparam int NpeW    = 5;
  localparam int NdvW    = 11;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [CmdW-1:0] CMD_INIT   = 2'd0;
  localparam logic [CmdW-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd2;

  localparam logic [NpeW-1:0] NpeReset = 5'd16;
  localparam logic [NdvW-1:0] NdvReset = 11'd1024;

  localparam logic signed [ValueW-1:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [ValueW-1:0] QMin = 32'sh8000_0000;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_UPDATE,
    OP_READ
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef enum logic [0:0] {
    REG_NUM_PATTERN_EDGES,
    REG_NUM_DATA_VERTICES
  } reg_idx_e;

  typedef struct packed {
    logic [NpeW-1:0] num_pattern_edges;
    logic [NdvW-1:0] num_data_vertices;
  } cfg_t;

  // Classified item as it waits between front and back.
  typedef struct packed {
    op_e                       op;
    logic                      err;
    logic [VertexW-1:0]        vertex;
    logic [EdgeW-1:0]          pattern_edge;
    logic signed [ValueW-1:0]  value;
  } item_t;

  typedef struct packed {
    logic  empty;
    item_t head;
  } q_status_t;

  // a - b clamped to the 32-bit signed range
  function automatic logic signed [ValueW-1:0] sat_sub(
    input logic signed [ValueW-1:0] a,
    input logic signed [ValueW-1:0] b
  );
    logic signed [ValueW:0] diff;
    logic signed [ValueW-1:0] res;
    diff = {a[ValueW-1], a} - {b[ValueW-1], b};
    if (diff[ValueW] != diff[ValueW-1]) begin
      res = diff[ValueW] ? QMin : QMax;
    end else begin
      res = diff[ValueW-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/vest_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface vest_in_if import vest_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CmdW-1:0]           command;
  logic [VertexW-1:0]        vertex;
  logic [EdgeW-1:0]          pattern_edge;
  logic signed [ValueW-1:0]  value;
  logic signed [ValueW-1:0]  null_cost;

  modport source (output valid, command, vertex, pattern_edge, value, null_cost,
                  input ready);
  modport sink (input valid, command, vertex, pattern_edge, value, null_cost,
                output ready);
endinterface
`default_nettype wire

[rtl/vest_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface vest_out_if import vest_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ValueW-1:0]  entry_value;
  logic                      error;

  modport source (output valid, entry_value, error, input ready);
  modport sink (input valid, entry_value, error, output ready);
endinterface
`default_nettype wire

[rtl/vest_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module vest_regs import vest_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  // word address, byte offset ignored
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_NUM_PATTERN_EDGES: cfg_d.num_pattern_edges = pwdata[NpeW-1:0];
        REG_NUM_DATA_VERTICES: cfg_d.num_data_vertices = pwdata[NdvW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUM_PATTERN_EDGES: prdata = ApbDataW'(cfg_q.num_pattern_edges);
      REG_NUM_DATA_VERTICES: prdata = ApbDataW'(cfg_q.num_data_vertices);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_pattern_edges <= NpeReset;
      cfg_q.num_data_vertices <= NdvReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[rtl/vest_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module vest_front import vest_pkg::*; #(
  parameter int MAX_VERTICES      = MaxVerticesDef,
  parameter int MAX_PATTERN_EDGES = MaxPatternEdgesDef
) (
  vest_in_if.sink      in_i,
  input  cfg_t         cfg_i,
  input  wire logic    full_i,
  output logic         push_o,
  output item_t        item_o
);

  logic err;

  // range check against live counts and table size
  assign err = (NdvW'(in_i.vertex) >= cfg_i.num_data_vertices) ||
               (NpeW'(in_i.pattern_edge) >= cfg_i.num_pattern_edges) ||
               (int'(in_i.vertex) >= MAX_VERTICES) ||
               (int'(in_i.pattern_edge) >= MAX_PATTERN_EDGES);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.err          = err;
    item_o.vertex       = in_i.vertex;
    item_o.pattern_edge = in_i.pattern_edge;
    item_o.value        = in_i.value;
    case (in_i.command)
      CMD_INIT: begin
        item_o.op    = OP_INIT;
        item_o.value = sat_sub(in_i.value, in_i.null_cost);
      end
      CMD_UPDATE: item_o.op = OP_UPDATE;
      CMD_READ:   item_o.op = OP_READ;
      default:    item_o.op = OP_READ;  // unused code reads
    endcase
  end

endmodule
`default_nettype wire

[rtl/vest_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module vest_queue import vest_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output q_status_t  status_o
);

  item_t              slot_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]     count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (QPtrW+1)'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  assign status_o.empty = (count_q == '0);
  assign status_o.head  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

[rtl/vest_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module vest_back import vest_pkg::*; #(
  parameter int MAX_VERTICES      = MaxVerticesDef,
  parameter int MAX_PATTERN_EDGES = MaxPatternEdgesDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  q_status_t  q_i,
  output logic       pop_o,
  vest_out_if.source out_o
);

  localparam int Depth = MAX_VERTICES * MAX_PATTERN_EDGES;
  localparam int AddrW = $clog2(Depth);

  logic signed [ValueW-1:0] mem [Depth];

  back_state_e              state_q, state_d;
  item_t                    item_q;
  logic [AddrW-1:0]         addr_q, rd_addr;
  logic signed [ValueW-1:0] rd_data_q, new_val;
  logic                     rd_en, wr_en, out_load;
  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic                     out_error_q;

  assign rd_addr = AddrW'(int'(q_i.head.vertex) * MAX_PATTERN_EDGES +
                          int'(q_i.head.pattern_edge));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_i.empty) state_d = BK_EXEC;
      BK_EXEC: if (!out_valid_q || out_o.ready) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    wr_en    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_o = !q_i.empty;
        rd_en = !q_i.empty && !q_i.head.err;
      end
      BK_EXEC: begin
        out_load = !out_valid_q || out_o.ready;
        wr_en    = out_load && !item_q.err && (item_q.op != OP_READ);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (item_q.op)
      OP_INIT:   new_val = item_q.value;
      OP_UPDATE: new_val = (item_q.value > rd_data_q) ? item_q.value : rd_data_q;
      OP_READ:   new_val = rd_data_q;
      default:   new_val = rd_data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_i.head;
      addr_q <= rd_addr;
    end
    if (out_load) begin
      out_value_q <= item_q.err ? '0 : new_val;
      out_error_q <= item_q.err;
    end
  end

  // single-port table: read on pop, write on delivery, never together
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= new_val;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_value = out_value_q;
  assign out_o.error       = out_error_q;

endmodule
`default_nettype wire

[rtl/vertex_edge_scatter_max_table.sv]
// Channel  | Dir | Handshake   | Payload
// in_i     | in  | valid/ready | command, vertex, pattern_edge, value, null_cost
// out_o    | out | valid/ready | entry_value, error
// APB      | in  | psel/penable/pready | num_pattern_edges @0x0, num_data_vertices @0x4
//
// The table is a single-port memory: the back end reads the entry in BK_IDLE and
// writes it back in BK_EXEC once the result register is free, and pops the next
// item only after that write. Items pass the queue, item and result registers.
// A 2-entry queue lets the front keep taking items while a result is stalled.
// Async active-low reset clears control; table contents are undefined until
// written (no clearing pass).
`timescale 1ns / 1ps
`default_nettype none
module vertex_edge_scatter_max_table import vest_pkg::*; #(
  parameter int MAX_VERTICES      = MaxVerticesDef,
  parameter int MAX_PATTERN_EDGES = MaxPatternEdgesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  vest_in_if.sink                  in_i,
  vest_out_if.source               out_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  cfg_t      cfg;
  item_t     push_item;
  logic      push, full, pop;
  q_status_t q_status;

  // config registers; to be written only while the block is idle (not enforced by the block)
  vest_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: range check, command decode, init saturation
  vest_front #(
    .MAX_VERTICES      (MAX_VERTICES),
    .MAX_PATTERN_EDGES (MAX_PATTERN_EDGES)
  ) u_front (
    .in_i   (in_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // decouples classification from the table access
  vest_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .full_o   (full),
    .pop_i    (pop),
    .status_o (q_status)
  );

  // back: table read-modify-write and result register
  vest_back #(
    .MAX_VERTICES      (MAX_VERTICES),
    .MAX_PATTERN_EDGES (MAX_PATTERN_EDGES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_status),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

[rtl/vest_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_edge_scatter_max_table_macros.svh"
module vest_checker import vest_pkg::*; (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [ValueW-1:0]  out_entry_value,
  input wire logic                      out_error,
  input wire logic                      psel,
  input wire logic                      penable,
  input wire logic                      pwrite,
  input wire logic [ApbAddrW-1:0]       paddr,
  input wire logic [ApbDataW-1:0]       pwdata,
  input wire logic [ApbDataW-1:0]       prdata,
  input wire logic                      pready
);

  `VEST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `VEST_ASSERT(a_out_stable,
    out_valid && !out_ready |=> $stable(out_entry_value) && $stable(out_error),
    "stalled result changed")
  `VEST_ASSERT(a_err_zero, out_valid && out_error |-> out_entry_value == '0, "error result not zero")
  `VEST_ASSERT_ALWAYS(a_pready, pready, "pready low")
  `VEST_ASSERT(a_npe_readback,
    (psel && penable && pwrite && (paddr[2] == REG_NUM_PATTERN_EDGES)) ##1
    (paddr[2] == REG_NUM_PATTERN_EDGES) |-> prdata[NpeW-1:0] == $past(pwdata[NpeW-1:0]),
    "pattern edge count readback mismatch")

endmodule

bind vertex_edge_scatter_max_table vest_checker u_vest_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_entry_value (out_o.entry_value),
  .out_error       (out_o.error),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .pready          (pready)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import vest_pkg::*;

  // Command code the block treats as a read; the package has no name for it.
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;
  localparam int TableDepth = MaxVerticesDef * MaxPatternEdgesDef;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic [VertexW-1:0]       vertex;
    logic [EdgeW-1:0]         pattern_edge;
    logic signed [ValueW-1:0] value;
    logic signed [ValueW-1:0] null_cost;
  } table_op_t;

  typedef struct packed {
    logic signed [ValueW-1:0] entry_value;
    logic                     error;
  } entry_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  vest_in_if  in_ch ();
  vest_out_if out_ch ();

  vertex_edge_scatter_max_table dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the table and of the two limit registers.
  logic signed [ValueW-1:0] entry_shadow [TableDepth];
  bit                       entry_written [TableDepth];
  logic [NpeW-1:0]          npe_cfg;
  logic [NdvW-1:0]          ndv_cfg;

  // Results still owed by the block, oldest first.
  entry_result_t pending_entries [$];

  int  fail_count;
  int  items_sent;
  int  results_checked;
  int  error_results;
  int  limit_settings;
  // When set, that side never idles: back-to-back stretches.
  bit  source_calm;
  bit  sink_calm;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run (~1 ms).
  initial begin
    #10_000_000;
    $display("[vertex_edge_scatter_max_table] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Both indexes must sit below the programmed counts; the widths already keep
  // them inside the table.
  function automatic bit op_in_range(input table_op_t op);
    return (int'(op.vertex) < int'(npe_cfg) * 0 + int'(ndv_cfg)) &&
           (int'(op.pattern_edge) < int'(npe_cfg));
  endfunction

  function automatic int entry_addr(input table_op_t op);
    return int'(op.vertex) * MaxPatternEdgesDef + int'(op.pattern_edge);
  endfunction

  // Never touch an entry that has no defined contents: an in-range read, update or
  // spare-code item on an unwritten entry is turned into an init of it.
  function automatic table_op_t legalize(input table_op_t op);
    table_op_t fixed;
    fixed = op;
    if (op_in_range(op) && !entry_written[entry_addr(op)] && op.command != CMD_INIT) begin
      fixed.command = CMD_INIT;
    end
    return fixed;
  endfunction

  // Apply one accepted item to the shadow table, return what the block owes.
  function automatic entry_result_t apply_table_op(input table_op_t op);
    entry_result_t            res;
    int                       addr;
    longint                   diff;
    logic signed [ValueW-1:0] cur;
    res = '0;
    if (!op_in_range(op)) begin
      // out of range: table untouched, value reads as zero
      res.error = 1'b1;
      return res;
    end
    addr = entry_addr(op);
    cur  = entry_shadow[addr];
    case (op.command)
      CMD_INIT: begin
        diff = longint'($signed(op.value)) - longint'($signed(op.null_cost));
        if (diff > longint'(QMax)) begin
          cur = QMax;
        end else if (diff < longint'(QMin)) begin
          cur = QMin;
        end else begin
          cur = diff[ValueW-1:0];
        end
        entry_written[addr] = 1'b1;
      end
      CMD_UPDATE: begin
        if ($signed(op.value) > $signed(cur)) begin
          cur = op.value;
        end
      end
      default: begin
        // read and the spare code leave the entry alone
      end
    endcase
    entry_shadow[addr] = cur;
    res.entry_value    = cur;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  task automatic send_op(input table_op_t raw);
    table_op_t     op;
    entry_result_t want;
    int            gap;
    op  = legalize(raw);
    gap = source_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= op.command;
    in_ch.vertex       <= op.vertex;
    in_ch.pattern_edge <= op.pattern_edge;
    in_ch.value        <= op.value;
    in_ch.null_cost    <= op.null_cost;
    do @(posedge clk_i); while (!in_ch.ready);
    // accepted at this edge: predict in acceptance order
    want = apply_table_op(op);
    pending_entries.push_back(want);
    items_sent++;
    if (want.error) begin
      error_results++;
    end
  endtask

  // Stop sending, let every owed result come back, then idle so the pipe can settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic table_op_t make_op(input logic [CmdW-1:0] cmd, input int vtx,
                                        input int edg, input logic signed [ValueW-1:0] val,
                                        input logic signed [ValueW-1:0] ncost);
    table_op_t op;
    op.command      = cmd;
    op.vertex       = VertexW'(vtx);
    op.pattern_edge = EdgeW'(edg);
    op.value        = val;
    op.null_cost    = ncost;
    return op;
  endfunction

  // Q16.16 operand: rails, zero, small values within +/-8.0, or anything at all.
  function automatic logic signed [ValueW-1:0] rand_q();
    case ($urandom_range(0, 7))
      0:       return QMax;
      1:       return QMin;
      2:       return '0;
      3, 4:    return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // Half of the vertices fall in a small hot set so updates pile onto the same
  // entries; the rest land near the programmed limits or anywhere.
  function automatic table_op_t random_table_op();
    table_op_t op;
    int        sel;
    int        v;
    int        e;
    int        top;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      v = $urandom_range(0, 7);
    end else if (sel < 75) begin
      v = int'(ndv_cfg) - 2 + $urandom_range(0, 3);
    end else begin
      v = $urandom_range(0, 1023);
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    top = (int'(npe_cfg) > 16) ? 16 : int'(npe_cfg);
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      e = (top > 0) ? $urandom_range(0, top - 1) : 0;
    end else if (sel < 80) begin
      e = top - 1 + $urandom_range(0, 1);
    end else begin
      e = $urandom_range(0, 15);
    end
    if (e < 0) e = 0;
    if (e > 15) e = 15;
    sel = $urandom_range(0, 99);
    op = make_op(sel < 25 ? CMD_INIT : sel < 65 ? CMD_UPDATE : sel < 88 ? CMD_READ : CmdSpare,
                 v, e, rand_q(), rand_q());
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver drops ready for a random stall before taking each result, none when sink_calm.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk_i) begin : result_check
    entry_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_entries.size() == 0) begin
        $error("result with no item pending: entry_value %0d error %0b",
               out_ch.entry_value, out_ch.error);
        fail_count++;
      end else begin
        want = pending_entries.pop_front();
        results_checked++;
        if (out_ch.entry_value !== want.entry_value) begin
          $error("entry_value mismatch: expected %0d, got %0d",
                 want.entry_value, out_ch.entry_value);
          fail_count++;
        end
        if (out_ch.error !== want.error) begin
          $error("error mismatch: expected %0b, got %0b", want.error, out_ch.error);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input reg_idx_e idx, output logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Read both limits back and hold them against the shadow copy.
  task automatic check_limits();
    logic [ApbDataW-1:0] rd;
    apb_read(REG_NUM_PATTERN_EDGES, rd);
    if (rd !== ApbDataW'(npe_cfg)) begin
      $error("num_pattern_edges mismatch: expected %0d, got %0d", npe_cfg, rd);
      fail_count++;
    end
    apb_read(REG_NUM_DATA_VERTICES, rd);
    if (rd !== ApbDataW'(ndv_cfg)) begin
      $error("num_data_vertices mismatch: expected %0d, got %0d", ndv_cfg, rd);
      fail_count++;
    end
  endtask

  // Caller drains the block first; limits only change while it is idle.
  task automatic set_limits(input int npe, input int ndv);
    npe_cfg = NpeW'(npe);
    ndv_cfg = NdvW'(ndv);
    apb_write(REG_NUM_PATTERN_EDGES, ApbDataW'(npe_cfg));
    apb_write(REG_NUM_DATA_VERTICES, ApbDataW'(ndv_cfg));
    check_limits();
    limit_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Limits come out of reset at full size.
  task automatic test_register_reset();
    npe_cfg = NpeReset;
    ndv_cfg = NdvReset;
    check_limits();
  endtask

  // Init saturation at both rails, max update above/below/equal, read and the
  // spare code, corner entries of the full table.
  task automatic test_init_and_max();
    source_calm = 1'b1;
    sink_calm   = 1'b1;
    send_op(make_op(CMD_INIT,   0,    0,  32'sh0001_8000, 32'sh0000_4000));
    send_op(make_op(CMD_INIT,   1023, 15, QMax,           QMin));
    send_op(make_op(CMD_INIT,   1023, 0,  QMin,           QMax));
    send_op(make_op(CMD_INIT,   0,    15, QMin,           32'sh0000_0000));
    send_op(make_op(CMD_INIT,   512,  8,  -32'sd1,        32'sd1));
    send_op(make_op(CMD_UPDATE, 0,    0,  32'sh0002_0000, 32'sh0));
    send_op(make_op(CMD_UPDATE, 0,    0,  -32'sd5,        QMax));
    send_op(make_op(CMD_UPDATE, 0,    0,  32'sh0002_0000, 32'sh0));
    send_op(make_op(CMD_UPDATE, 1023, 0,  QMin,           32'sh0));
    send_op(make_op(CMD_UPDATE, 1023, 0,  -32'sd1,        32'sh0));
    send_op(make_op(CMD_UPDATE, 1023, 15, QMin,           32'sh0));
    send_op(make_op(CMD_READ,   512,  8,  QMax,           QMin));
    send_op(make_op(CmdSpare,   0,    15, QMax,           QMax));
    send_op(make_op(CMD_UPDATE, 0,    15, QMax,           QMin));
    send_op(make_op(CMD_READ,   1023, 15, 32'sh0,         32'sh0));
    wait_idle();
  endtask

  // Limits at their extremes: tiny, full size, zero (everything flagged), oversized.
  task automatic test_bounds();
    set_limits(1, 1);
    send_op(make_op(CMD_READ,   0,    0,  32'sh0, 32'sh0));
    send_op(make_op(CMD_UPDATE, 1,    0,  QMax,   32'sh0));
    send_op(make_op(CMD_READ,   0,    1,  32'sh0, 32'sh0));
    send_op(make_op(CMD_INIT,   1023, 15, QMin,   QMax));
    wait_idle();
    // the flagged init above must not have reached the table
    set_limits(16, 1024);
    send_op(make_op(CMD_READ,   1023, 15, 32'sh0, 32'sh0));
    wait_idle();
    set_limits(0, 0);
    send_op(make_op(CMD_READ,   0,    0,  32'sh0, 32'sh0));
    send_op(make_op(CMD_INIT,   5,    3,  QMax,   32'sh0));
    wait_idle();
    set_limits(31, 2047);
    send_op(make_op(CMD_READ,   1023, 15, 32'sh0, 32'sh0));
    send_op(make_op(CmdSpare,   1023, 0,  32'sh0, 32'sh0));
    wait_idle();
  endtask

  // Short random bursts under a spread of fixed limits.
  task automatic test_config_sweep();
    int sweep_npe [6] = '{1, 16, 0, 31, 7, 2};
    int sweep_ndv [6] = '{1, 1024, 0, 2047, 300, 3};
    for (int s = 0; s < 6; s++) begin
      set_limits(sweep_npe[s], sweep_ndv[s]);
      source_calm = (s % 3 == 0);
      sink_calm   = (s % 2 == 0);
      for (int i = 0; i < 60; i++) begin
        send_op(random_table_op());
      end
      wait_idle();
    end
  endtask

  // Bulk traffic: new limits every 400 items, idling style every 100.
  task automatic test_random_traffic();
    for (int i = 0; i < 1600; i++) begin
      if (i % 400 == 0) begin
        wait_idle();
        set_limits(($urandom_range(0, 4) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1025, 2047)
                                               : $urandom_range(1, 1024));
      end
      if (i % 100 == 0) begin
        source_calm = ($urandom_range(0, 3) == 0);
        sink_calm   = ($urandom_range(0, 3) == 0);
      end
      send_op(random_table_op());
    end
    wait_idle();
  endtask

  initial begin
    fail_count      = 0;
    items_sent      = 0;
    results_checked = 0;
    error_results   = 0;
    limit_settings  = 0;
    source_calm     = 1'b0;
    sink_calm       = 1'b0;
    npe_cfg         = NpeReset;
    ndv_cfg         = NdvReset;
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_READ;
    in_ch.vertex       <= '0;
    in_ch.pattern_edge <= '0;
    in_ch.value        <= '0;
    in_ch.null_cost    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_init_and_max();
    test_bounds();
    test_config_sweep();
    test_random_traffic();

    // tail: nothing owed, pipe settled
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (pending_entries.size() != 0) begin
      $error("%0d results never arrived", pending_entries.size());
      fail_count++;
    end

    $display("Sent %0d items, checked %0d results (%0d flagged out of range).",
             items_sent, results_checked, error_results);
    $display("Covered %0d limit settings, %0d failures.", limit_settings, fail_count);
    if (fail_count == 0) begin
      $display("[vertex_edge_scatter_max_table] OK");
    end else begin
      $display("[vertex_edge_scatter_max_table] ERROR");
    end
    $finish;
  end

endmodule

[vertex_edge_scatter_max_table.f]
+incdir+rtl
rtl/vest_pkg.sv
rtl/vest_in_if.sv
rtl/vest_out_if.sv
rtl/vest_regs.sv
rtl/vest_front.sv
rtl/vest_queue.sv
rtl/vest_back.sv
rtl/vertex_edge_scatter_max_table.sv
rtl/vest_checker.sv
tb/tb.sv
